>>> rtl/core/fat12_next_sector_lookup_macros.svh
// assertion helpers shared by the lookup block
`ifndef FAT12_NEXT_SECTOR_LOOKUP_MACROS_SVH
`define FAT12_NEXT_SECTOR_LOOKUP_MACROS_SVH

// same-cycle implication, checked out of reset
`define FNSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FNSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/fnsl_pkg.sv
package fnsl_pkg;

    // table store size in bytes, split over an even and an odd byte bank
    localparam int FAT_STORE_BYTES = 8192;
    localparam int BANK_DEPTH      = (FAT_STORE_BYTES + 1) / 2;
    localparam int BANK_AW         = $clog2(BANK_DEPTH);

    localparam int SECTOR_W  = 13;
    localparam int BADDR_W   = 13;
    localparam int BYTE_W    = 8;
    localparam int ENTRY_W   = 12;
    localparam int OFFSET_W  = 8;
    // n*3 for a 13-bit n
    localparam int PROD_W    = SECTOR_W + 2;

    localparam logic [ENTRY_W-1:0]  END_MARK       = 12'hFFF;
    localparam logic [OFFSET_W-1:0] OFFSET_DEFAULT = 8'd31;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FAT_READY     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_OFFSET = 1'd1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_END       = 3'd1,
        ST_NOT_READY = 3'd2,
        ST_END_INPUT = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

endpackage

>>> rtl/core/fnsl_if.sv
// request channel: table byte writes and next-sector queries
interface fnsl_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [fnsl_pkg::BADDR_W-1:0]  byte_address;
    logic [fnsl_pkg::BYTE_W-1:0]   byte_value;
    logic [fnsl_pkg::SECTOR_W-1:0] sector;

    modport source (output valid, action, byte_address, byte_value, sector, input ready);
    modport sink   (input valid, action, byte_address, byte_value, sector, output ready);
endinterface

// response channel: one transfer per request
interface fnsl_rsp_if;
    logic                          valid;
    logic                          ready;
    fnsl_pkg::t_status             status;
    logic [fnsl_pkg::SECTOR_W-1:0] next_sector;

    modport source (output valid, status, next_sector, input ready);
    modport sink   (input valid, status, next_sector, output ready);
endinterface

>>> rtl/core/fat12_next_sector_lookup.sv
// FAT12 next-sector lookup. A request transfer with action 0 writes one byte of the
// allocation table into the on-chip store (addresses past the store are dropped); one with
// action 1 asks for the sector that follows 'sector' in its cluster chain. Every request gives
// exactly one response, in order: writes answer status ok with next_sector 0, queries answer
// ok plus the successor (entry + sector_offset), end of chain, not ready (fat_ready clear),
// end-marker input (sector 0xFFF) or out of range (sector below the offset, or an entry whose
// bytes run past the store); next_sector is 0 for every status but ok. The store has no reset
// and must be loaded before it is queried. It is held as an even and an odd byte bank, so the
// two bytes of a packed entry come out of one read of each bank: the block takes one request
// per cycle while the response channel is not stalled, and each passes through the bank read,
// then the output register. Configuration writes are meant for idle periods only.
`include "fat12_next_sector_lookup_macros.svh"

module fat12_next_sector_lookup (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    fnsl_req_if.sink                           i_req,
    fnsl_rsp_if.source                         o_rsp,
    input  logic                               i_cfg_we,
    input  logic [fnsl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fnsl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fnsl_pkg::*;

    // configuration registers
    logic                r_fat_ready;
    logic [OFFSET_W-1:0] r_sector_offset;

    // byte banks
    logic [BYTE_W-1:0] r_mem_even [BANK_DEPTH];
    logic [BYTE_W-1:0] r_mem_odd  [BANK_DEPTH];
    logic [BYTE_W-1:0] r_rd_even;
    logic [BYTE_W-1:0] r_rd_odd;

    // read stage
    logic                r_s1_valid;
    logic                r_s1_lookup;
    t_status             r_s1_status;
    logic                r_s1_n_odd;
    logic                r_s1_idx_odd;
    logic [OFFSET_W-1:0] r_s1_offset;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [SECTOR_W-1:0] r_out_next;

    logic                s1_adv;
    logic                in_accept;
    logic                is_query;
    logic [SECTOR_W-1:0] ent_n;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   idx_nxt;
    logic                wr_ok;
    logic                wr_even;
    logic                wr_odd;
    logic                rd_en;
    logic [BANK_AW-1:0]  wr_addr;
    logic [BANK_AW-1:0]  ev_addr;
    logic [BANK_AW-1:0]  od_addr;
    t_status             n_s1_status;
    logic                n_s1_lookup;

    logic [BYTE_W-1:0]   lo_byte;
    logic [BYTE_W-1:0]   hi_byte;
    logic [15:0]         word;
    logic [ENTRY_W-1:0]  entry;
    t_status             n_out_status;
    logic [SECTOR_W-1:0] n_out_next;

    // handshake: the read stage moves on whenever the output register is free or drained
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign in_accept   = i_req.valid && i_req.ready;
    assign is_query    = (i_req.action == ACT_QUERY);

    // entry number and byte index (n*3)>>1, plus the index of the second byte
    assign ent_n   = i_req.sector - SECTOR_W'(r_sector_offset);
    assign prod    = PROD_W'(ent_n) + PROD_W'({ent_n, 1'b0});
    assign idx_nxt = PROD_W'(prod[PROD_W-1:1]) + PROD_W'(1);

    // byte idx sits in bank idx[0]; the other byte is in the other bank
    assign od_addr = prod[BANK_AW+1:2];
    assign ev_addr = idx_nxt[BANK_AW:1];

    // early status of a query; only a clean query needs the table
    always_comb begin
        n_s1_status = ST_OK;
        n_s1_lookup = 1'b0;
        if (is_query) begin
            if (!r_fat_ready) begin
                n_s1_status = ST_NOT_READY;
            end else if (i_req.sector == SECTOR_W'(END_MARK)) begin
                n_s1_status = ST_END_INPUT;
            end else if (i_req.sector < SECTOR_W'(r_sector_offset)) begin
                n_s1_status = ST_RANGE;
            end else if (idx_nxt >= PROD_W'(FAT_STORE_BYTES)) begin
                n_s1_status = ST_RANGE;
            end else begin
                n_s1_lookup = 1'b1;
            end
        end
    end

    assign rd_en   = in_accept && n_s1_lookup;
    assign wr_ok   = PROD_W'(i_req.byte_address) < PROD_W'(FAT_STORE_BYTES);
    assign wr_even = in_accept && !is_query && wr_ok && !i_req.byte_address[0];
    assign wr_odd  = in_accept && !is_query && wr_ok && i_req.byte_address[0];
    assign wr_addr = i_req.byte_address[BANK_AW:1];

    // byte banks: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (wr_even) begin
            r_mem_even[wr_addr] <= i_req.byte_value;
        end
        if (rd_en) begin
            r_rd_even <= r_mem_even[ev_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_odd) begin
            r_mem_odd[wr_addr] <= i_req.byte_value;
        end
        if (rd_en) begin
            r_rd_odd <= r_mem_odd[od_addr];
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fat_ready     <= 1'b0;
            r_sector_offset <= OFFSET_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FAT_READY:     r_fat_ready     <= i_cfg_data[0];
                CFG_SECTOR_OFFSET: r_sector_offset <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_lookup  <= n_s1_lookup;
            r_s1_status  <= n_s1_status;
            r_s1_n_odd   <= ent_n[0];
            r_s1_idx_odd <= prod[1];
            r_s1_offset  <= r_sector_offset;
        end
    end

    // unpack the 12-bit entry from the little-endian byte pair
    assign lo_byte = r_s1_idx_odd ? r_rd_odd  : r_rd_even;
    assign hi_byte = r_s1_idx_odd ? r_rd_even : r_rd_odd;
    assign word    = {hi_byte, lo_byte};
    assign entry   = r_s1_n_odd ? word[15:4] : word[11:0];

    always_comb begin
        n_out_status = r_s1_status;
        n_out_next   = '0;
        if (r_s1_lookup) begin
            if (entry == END_MARK) begin
                n_out_status = ST_END;
            end else begin
                n_out_status = ST_OK;
                n_out_next   = SECTOR_W'(entry) + SECTOR_W'(r_s1_offset);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_status <= n_out_status;
            r_out_next   <= n_out_next;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.next_sector = r_out_next;

    // checks
    `FNSL_ASSERT_NOW(a_next_zero_unless_ok, i_clk, i_rst_n,
        o_rsp.valid && (o_rsp.status != ST_OK), o_rsp.next_sector == '0,
        "next_sector not zero on a failed lookup")
    `FNSL_ASSERT_NEXT(a_not_ready_refused, i_clk, i_rst_n,
        in_accept && is_query && !r_fat_ready,
        r_s1_valid && !r_s1_lookup && (r_s1_status == ST_NOT_READY),
        "query taken to the table while not ready")
    `FNSL_ASSERT_NEXT(a_write_no_lookup, i_clk, i_rst_n,
        in_accept && !is_query, r_s1_valid && !r_s1_lookup && (r_s1_status == ST_OK),
        "byte write did not answer ok")
    `FNSL_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n,
        r_s1_valid && !s1_adv,
        r_s1_valid && $stable(r_s1_status) && (!r_s1_lookup || $stable(r_rd_even)),
        "read stage lost its contents while stalled")

endmodule
